>>> hdl/isr_pkg.sv
// Shared types and constants of the Ising ring spin-flip update core.
package isr_pkg;

    localparam int SITE_W = 10;
    localparam int RND_W  = 16;
    localparam int THR_W  = 17;
    localparam int OUT_W  = 12;
    localparam int CNT_W  = 32;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 96;

    typedef enum logic [1:0] {
        OP_ATTEMPT = 2'd0,
        OP_LOAD    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GIBBS     = 3'd0,
        REG_THR_DN_N2 = 3'd1,
        REG_THR_DN_Z  = 3'd2,
        REG_THR_DN_P2 = 3'd3,
        REG_THR_UP_N2 = 3'd4,
        REG_THR_UP_Z  = 3'd5,
        REG_THR_UP_P2 = 3'd6,
        REG_NONE      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_SITE,
        S_RD_LEFT,
        S_RD_RIGHT,
        S_RD_LAST,
        S_EXEC
    } t_state;

    localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

endpackage

>>> hdl/ising_ring_spin_flip_update_core.sv
// Top level of the Ising ring single-spin-flip update core.
// The ring of NUM_SPINS one-bit spins lives in a single-read-port RAM. After reset a
// clearing pass writes every spin to -1, during which no word is accepted (configuration
// writes are taken). Each word then passes accept, three reads (site, left and right
// neighbor) through the one RAM read port, a wait for the last read, and an execute state
// that writes a flipped spin back and loads the result, held while the output stalls. The
// next word is accepted in the cycle after execute; a result waits in the output register.
module ising_ring_spin_flip_update_core #(
    parameter int NUM_SPINS = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [isr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [isr_pkg::THR_W-1:0]         i_cfg_wdata,
    // input words
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: site[9:0], random_value[25:10], load_value[26], zero fill
    input  logic [isr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: op[1:0]
    input  logic [1:0]                        i_s_axis_tuser,
    // result words
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata: flipped[0], spin_after[1], bond_sum[13:2], magnetization[25:14],
    //        attempted_count[57:26], accepted_count[89:58], zero fill
    output logic [isr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    localparam int AW = $clog2(NUM_SPINS);
    localparam int TW = $clog2(NUM_SPINS + 1) + 2;
    localparam int EW = (TW > isr_pkg::OUT_W) ? TW : isr_pkg::OUT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SPINS - 1);
    localparam logic signed [TW-1:0] BOND_RST = TW'(NUM_SPINS);
    localparam logic signed [TW-1:0] MAG_RST  = TW'(-NUM_SPINS);
    localparam logic signed [TW-1:0] STEP2 = TW'(2);
    localparam logic signed [TW-1:0] STEP4 = TW'(4);
    localparam logic signed [EW-1:0] SAT_HI = EW'(2047);
    localparam logic signed [EW-1:0] SAT_LO = EW'(-2048);
    localparam logic [isr_pkg::CNT_W-1:0] CNT_MAX = '1;

    // configuration registers
    logic                        r_gibbs;
    logic [isr_pkg::THR_W-1:0]   r_thr [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gibbs <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_thr[k] <= isr_pkg::THR_RESET;
            end
        end else if (i_cfg_wr_en) begin
            unique case (isr_pkg::t_reg_idx'(i_cfg_index))
                isr_pkg::REG_GIBBS:     r_gibbs  <= i_cfg_wdata[0];
                isr_pkg::REG_THR_DN_N2: r_thr[0] <= i_cfg_wdata;
                isr_pkg::REG_THR_DN_Z:  r_thr[1] <= i_cfg_wdata;
                isr_pkg::REG_THR_DN_P2: r_thr[2] <= i_cfg_wdata;
                isr_pkg::REG_THR_UP_N2: r_thr[3] <= i_cfg_wdata;
                isr_pkg::REG_THR_UP_Z:  r_thr[4] <= i_cfg_wdata;
                isr_pkg::REG_THR_UP_P2: r_thr[5] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer
    isr_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_clr_addr;
    logic            w_accept;
    logic            w_go;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_go     = (r_state == isr_pkg::S_EXEC) && (!o_m_axis_tvalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            isr_pkg::S_CLEAR:    if (r_clr_addr == LAST_ADDR) n_state = isr_pkg::S_IDLE;
            isr_pkg::S_IDLE:     if (w_accept) n_state = isr_pkg::S_RD_SITE;
            isr_pkg::S_RD_SITE:  n_state = isr_pkg::S_RD_LEFT;
            isr_pkg::S_RD_LEFT:  n_state = isr_pkg::S_RD_RIGHT;
            isr_pkg::S_RD_RIGHT: n_state = isr_pkg::S_RD_LAST;
            isr_pkg::S_RD_LAST:  n_state = isr_pkg::S_EXEC;
            isr_pkg::S_EXEC:     if (w_go) n_state = isr_pkg::S_IDLE;
            default:             n_state = isr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= isr_pkg::S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == isr_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // captured word
    isr_pkg::t_op            r_op;
    logic [isr_pkg::RND_W-1:0] r_rnd;
    logic                    r_ld;
    logic                    r_valid;
    logic [AW-1:0]           r_addr, r_left, r_right;
    logic                    r_s, r_l, r_r;

    logic [isr_pkg::SITE_W-1:0] w_site;
    logic                       w_site_ok;
    logic [AW-1:0]              w_addr;

    assign w_site    = i_s_axis_tdata[9:0];
    assign w_site_ok = 32'(w_site) < NUM_SPINS;
    assign w_addr    = w_site_ok ? AW'(w_site) : '0;

    // spin memory
    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    logic          w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    logic          w_ram_rdata;

    isr_ram #(
        .WIDTH (1),
        .DEPTH (NUM_SPINS)
    ) u_spin_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // execute logic
    logic [1:0]                w_cls;
    logic [isr_pkg::THR_W-1:0] w_thr;
    logic                      w_flip;
    logic                      w_attempt;

    assign w_cls = {1'b0, r_l} + {1'b0, r_r};

    always_comb begin
        case ({r_s, w_cls})
            3'b000:  w_thr = r_thr[0];
            3'b001:  w_thr = r_thr[1];
            3'b010:  w_thr = r_thr[2];
            3'b100:  w_thr = r_thr[3];
            3'b101:  w_thr = r_thr[4];
            3'b110:  w_thr = r_thr[5];
            default: w_thr = r_thr[0];
        endcase
    end

    always_comb begin
        w_flip = 1'b0;
        if (r_valid) begin
            if (r_op == isr_pkg::OP_ATTEMPT) begin
                w_flip = {1'b0, r_rnd} < w_thr;
            end else if (r_op == isr_pkg::OP_LOAD) begin
                w_flip = r_s != r_ld;
            end
        end
    end

    assign w_attempt = r_valid && (r_op == isr_pkg::OP_ATTEMPT);

    // output decode of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_ram_raddr     = r_addr;
        w_ram_we        = 1'b0;
        w_ram_waddr     = r_addr;
        w_ram_wdata     = ~r_s;
        unique case (r_state)
            isr_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = 1'b0;
            end
            isr_pkg::S_IDLE:     o_s_axis_tready = 1'b1;
            isr_pkg::S_RD_SITE:  w_ram_raddr = r_addr;
            isr_pkg::S_RD_LEFT:  w_ram_raddr = r_left;
            isr_pkg::S_RD_RIGHT: w_ram_raddr = r_right;
            isr_pkg::S_RD_LAST:  w_ram_raddr = r_addr;
            isr_pkg::S_EXEC:     w_ram_we = w_go && w_flip;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= isr_pkg::t_op'(i_s_axis_tuser);
            r_rnd   <= i_s_axis_tdata[25:10];
            r_ld    <= i_s_axis_tdata[26];
            r_valid <= w_site_ok;
            r_addr  <= w_addr;
            r_left  <= (w_addr == '0) ? LAST_ADDR : w_addr - AW'(1);
            r_right <= (w_addr == LAST_ADDR) ? '0 : w_addr + AW'(1);
        end
        if (r_state == isr_pkg::S_RD_LEFT)  r_s <= w_ram_rdata;
        if (r_state == isr_pkg::S_RD_RIGHT) r_l <= w_ram_rdata;
        if (r_state == isr_pkg::S_RD_LAST)  r_r <= w_ram_rdata;
    end

    // totals and counters
    logic signed [TW-1:0]      r_bond, r_mag, n_bond, n_mag;
    logic [isr_pkg::CNT_W-1:0] r_att, r_acc, n_att, n_acc;

    always_comb begin
        n_bond = r_bond;
        n_mag  = r_mag;
        n_att  = r_att;
        n_acc  = r_acc;
        if (w_flip) begin
            n_mag = r_s ? r_mag - STEP2 : r_mag + STEP2;
            if (w_cls == 2'd0) begin
                n_bond = r_s ? r_bond + STEP4 : r_bond - STEP4;
            end else if (w_cls == 2'd2) begin
                n_bond = r_s ? r_bond - STEP4 : r_bond + STEP4;
            end
        end
        if (r_op == isr_pkg::OP_CLEAR) begin
            n_att = '0;
            n_acc = '0;
        end else if (w_attempt) begin
            if (r_att != CNT_MAX) n_att = r_att + 1'b1;
            if ((r_gibbs || w_flip) && r_acc != CNT_MAX) n_acc = r_acc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bond <= BOND_RST;
            r_mag  <= MAG_RST;
            r_att  <= '0;
            r_acc  <= '0;
        end else if (w_go) begin
            r_bond <= n_bond;
            r_mag  <= n_mag;
            r_att  <= n_att;
            r_acc  <= n_acc;
        end
    end

    // result register
    logic signed [EW-1:0]        w_bond_ext, w_mag_ext;
    logic [isr_pkg::OUT_W-1:0]   w_bond_sat, w_mag_sat;
    logic                        r_out_valid;
    logic [isr_pkg::OUT_DATA_W-1:0] r_out_data;

    assign w_bond_ext = EW'(n_bond);
    assign w_mag_ext  = EW'(n_mag);
    assign w_bond_sat = (w_bond_ext > SAT_HI) ? isr_pkg::OUT_W'(SAT_HI) :
                        (w_bond_ext < SAT_LO) ? isr_pkg::OUT_W'(SAT_LO) :
                        w_bond_ext[isr_pkg::OUT_W-1:0];
    assign w_mag_sat  = (w_mag_ext > SAT_HI) ? isr_pkg::OUT_W'(SAT_HI) :
                        (w_mag_ext < SAT_LO) ? isr_pkg::OUT_W'(SAT_LO) :
                        w_mag_ext[isr_pkg::OUT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_data <= {6'd0, n_acc, n_att, w_mag_sat, w_bond_sat,
                           r_valid & (r_s ^ w_flip), w_flip};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // checks
    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == isr_pkg::S_CLEAR || r_state == isr_pkg::S_EXEC))
        else $error("spin RAM written outside clear or execute");

    a_result_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == isr_pkg::S_EXEC)
        else $error("result word without an execute cycle");

    a_mag_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag[0] == BOND_RST[0])
        else $error("magnetization parity broken");

    a_bond_mod4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bond[1:0] == BOND_RST[1:0])
        else $error("bond sum not congruent to ring size mod 4");

    a_acc_le_att: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= r_att)
        else $error("accepted count above attempted count");

endmodule

>>> hdl/isr_ram.sv
// Generic synchronous RAM, one write port and one registered read port.
module isr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sim/testbench.sv
// Testbench for the Ising ring spin-flip update core: predicted results vs. streamed output.
`timescale 1ns / 100ps

module testbench;

    localparam int NUM_SPINS  = 1024;
    localparam int IDLE_LIMIT = 5000;

    typedef struct packed {
        logic                      flipped;
        logic                      spin_after;
        logic signed [11:0]        bond_sum;
        logic signed [11:0]        magnetization;
        logic [isr_pkg::CNT_W-1:0] attempted;
        logic [isr_pkg::CNT_W-1:0] accepted;
    } t_ring_result;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [isr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [isr_pkg::THR_W-1:0]      cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [isr_pkg::IN_DATA_W-1:0]  s_data = '0;
    logic [1:0]                     s_user = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [isr_pkg::OUT_DATA_W-1:0] m_data;

    // predictor state
    logic                      ring_spin [NUM_SPINS];
    int                        bond_acc;
    int                        magnet_acc;
    logic [isr_pkg::CNT_W-1:0] attempt_cnt;
    logic [isr_pkg::CNT_W-1:0] accept_cnt;
    logic                      gibbs_en;
    logic [isr_pkg::THR_W-1:0] flip_thr [6];

    t_ring_result expected_results [$];
    int           errors = 0;
    int           idle_cycles = 0;
    int           hold_req = 0;
    int           stall_left = 0;
    bit           quiet = 1'b0;

    ising_ring_spin_flip_update_core #(.NUM_SPINS(NUM_SPINS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #4 i_clk = ~i_clk;

    function automatic void reset_ring_model();
        for (int k = 0; k < NUM_SPINS; k++) ring_spin[k] = 1'b0;
        bond_acc    = NUM_SPINS;
        magnet_acc  = -NUM_SPINS;
        attempt_cnt = '0;
        accept_cnt  = '0;
        gibbs_en    = 1'b0;
        for (int k = 0; k < 6; k++) flip_thr[k] = isr_pkg::THR_RESET;
    endfunction

    function automatic logic [isr_pkg::CNT_W-1:0] sat_incr(logic [isr_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic void toggle_spin(int site, int left, int right);
        int s_old;
        int nsum;
        s_old = ring_spin[site] ? 1 : -1;
        nsum  = (ring_spin[left] ? 1 : -1) + (ring_spin[right] ? 1 : -1);
        bond_acc   -= 2 * s_old * nsum;
        magnet_acc -= 2 * s_old;
        ring_spin[site] = ~ring_spin[site];
    endfunction

    function automatic t_ring_result apply_spin_update(isr_pkg::t_op op,
                                                       logic [isr_pkg::SITE_W-1:0] site,
                                                       logic [isr_pkg::RND_W-1:0] rnd,
                                                       logic ld);
        t_ring_result res;
        int           s;
        int           left;
        int           right;
        int           cls;
        logic [isr_pkg::THR_W-1:0] thr;
        res = '0;
        s = int'(site);
        left  = (s == 0) ? NUM_SPINS - 1 : s - 1;
        right = (s + 1 == NUM_SPINS) ? 0 : s + 1;
        if (op == isr_pkg::OP_CLEAR) begin
            attempt_cnt = '0;
            accept_cnt  = '0;
        end
        if (op == isr_pkg::OP_ATTEMPT) begin
            cls = int'(ring_spin[left]) + int'(ring_spin[right]);
            thr = flip_thr[int'(ring_spin[s]) * 3 + cls];
            attempt_cnt = sat_incr(attempt_cnt);
            if ({1'b0, rnd} < thr) begin
                toggle_spin(s, left, right);
                res.flipped = 1'b1;
            end
            if (gibbs_en || res.flipped) accept_cnt = sat_incr(accept_cnt);
        end else if (op == isr_pkg::OP_LOAD) begin
            if (ring_spin[s] != ld) begin
                toggle_spin(s, left, right);
                res.flipped = 1'b1;
            end
        end
        res.spin_after    = ring_spin[s];
        res.bond_sum      = 12'(bond_acc);
        res.magnetization = 12'(magnet_acc);
        res.attempted     = attempt_cnt;
        res.accepted      = accept_cnt;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(isr_pkg::t_op op, logic [isr_pkg::SITE_W-1:0] site,
                             logic [isr_pkg::RND_W-1:0] rnd, logic ld);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {5'b0, ld, rnd, site};
        s_user  <= op;
        do @(posedge i_clk); while (!s_ready);
        expected_results.push_back(apply_spin_update(op, site, rnd, ld));
        @(negedge i_clk);
    endtask

    task automatic write_reg(isr_pkg::t_reg_idx idx, logic [isr_pkg::THR_W-1:0] val);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == isr_pkg::REG_GIBBS) gibbs_en = val[0];
        else if (idx != isr_pkg::REG_NONE) flip_thr[int'(idx) - 1] = val;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [isr_pkg::THR_W-1:0] pick_thr(int kind);
        int r;
        case (kind)
            1: return '0;
            2: return 17'd65536;
            3: return 17'($urandom_range(0, 131071));
            4: begin
                r = $urandom_range(0, 4);
                case (r)
                    0: return 17'd0;
                    1: return 17'd1;
                    2: return 17'd65535;
                    3: return 17'd65536;
                    default: return 17'($urandom_range(0, 65536));
                endcase
            end
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic configure_phase(int kind);
        isr_pkg::t_reg_idx idx;
        write_reg(isr_pkg::REG_GIBBS,
                  (kind == 1) ? 17'd1 : (kind == 2) ? 17'd0 : 17'($urandom_range(0, 1)));
        for (int k = 1; k <= 6; k++) begin
            idx = isr_pkg::t_reg_idx'(k);
            write_reg(idx, pick_thr(kind));
        end
    endtask

    task automatic send_random_item(int unsigned base);
        int unsigned                r;
        isr_pkg::t_op               op;
        logic [isr_pkg::SITE_W-1:0] site;
        logic [isr_pkg::RND_W-1:0]  rnd;
        r = $urandom_range(0, 99);
        if (r < 78) op = isr_pkg::OP_ATTEMPT;
        else if (r < 92) op = isr_pkg::OP_LOAD;
        else if (r < 96) op = isr_pkg::OP_CLEAR;
        else op = isr_pkg::OP_NOP;
        // half the words hit a small window so neighbors interact back to back
        if ($urandom_range(0, 1)) site = isr_pkg::SITE_W'(base + $urandom_range(0, 7));
        else site = isr_pkg::SITE_W'($urandom);
        r = $urandom_range(0, 19);
        rnd = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : isr_pkg::RND_W'($urandom);
        send_word(op, site, rnd, 1'($urandom));
    endtask

    task automatic run_random(int count);
        int unsigned base;
        base = $urandom_range(0, NUM_SPINS - 1);
        for (int n = 0; n < count; n++) begin
            if (n % 32 == 31) base = $urandom_range(0, NUM_SPINS - 1);
            send_random_item(base);
        end
    endtask

    task automatic test_reset_thresholds();
        send_word(isr_pkg::OP_ATTEMPT, 10'd0, 16'hFFFF, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd1023, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd0, 16'd32767, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd0, 16'd32768, 1'b1);
        wait_idle();
    endtask

    task automatic test_directed_classes();
        write_reg(isr_pkg::REG_GIBBS, 17'd1);
        write_reg(isr_pkg::REG_THR_DN_N2, 17'd0);
        write_reg(isr_pkg::REG_THR_DN_Z, 17'd65536);
        write_reg(isr_pkg::REG_THR_DN_P2, 17'd131071);
        write_reg(isr_pkg::REG_THR_UP_N2, 17'd1);
        write_reg(isr_pkg::REG_THR_UP_Z, 17'd65535);
        write_reg(isr_pkg::REG_THR_UP_P2, 17'd0);
        // out-of-range index must leave the table alone
        write_reg(isr_pkg::REG_NONE, 17'h1FFFF);
        send_word(isr_pkg::OP_LOAD, 10'd512, 16'h0000, 1'b1);
        send_word(isr_pkg::OP_LOAD, 10'd512, 16'hFFFF, 1'b1);
        send_word(isr_pkg::OP_ATTEMPT, 10'd511, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd513, 16'hFFFF, 1'b1);
        send_word(isr_pkg::OP_ATTEMPT, 10'd100, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_LOAD, 10'd100, 16'h0000, 1'b1);
        send_word(isr_pkg::OP_ATTEMPT, 10'd100, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd512, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_LOAD, 10'd200, 16'h0000, 1'b1);
        send_word(isr_pkg::OP_LOAD, 10'd201, 16'h0000, 1'b1);
        send_word(isr_pkg::OP_ATTEMPT, 10'd200, 16'd65534, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd201, 16'd65535, 1'b0);
        send_word(isr_pkg::OP_CLEAR, 10'd1023, 16'hFFFF, 1'b1);
        send_word(isr_pkg::OP_NOP, 10'd5, 16'hA5A5, 1'b1);
        send_word(isr_pkg::OP_LOAD, 10'd0, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_LOAD, 10'd1023, 16'h0000, 1'b0);
        wait_idle();
        write_reg(isr_pkg::REG_GIBBS, 17'd0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd100, 16'h0000, 1'b0);
        send_word(isr_pkg::OP_ATTEMPT, 10'd511, 16'h0000, 1'b0);
        wait_idle();
    endtask

    task automatic test_random_phases();
        int kinds [6] = '{0, 3, 4, 1, 2, 0};
        for (int p = 0; p < 6; p++) begin
            configure_phase(kinds[p]);
            run_random(300);
            wait_idle();
        end
    endtask

    task automatic test_output_backpressure();
        configure_phase(4);
        hold_req = 300;
        run_random(40);
        wait_idle();
    endtask

    task automatic test_no_idle_stream();
        configure_phase(0);
        quiet = 1'b1;
        run_random(40);
        wait_idle();
        quiet = 1'b0;
    endtask

    // result sink: random stalls, forced long hold-off on request
    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req = 0;
            end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_ring_result exp_r;
        t_ring_result got;
        if (i_rst_n && m_valid && m_ready) begin
            got.flipped       = m_data[0];
            got.spin_after    = m_data[1];
            got.bond_sum      = m_data[13:2];
            got.magnetization = m_data[25:14];
            got.attempted     = m_data[57:26];
            got.accepted      = m_data[89:58];
            if (expected_results.size() == 0) begin
                $error("unexpected result word %h", m_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.flipped !== exp_r.flipped) begin
                    $error("flipped: expected %0d, got %0d", exp_r.flipped, got.flipped);
                    errors++;
                end
                if (got.spin_after !== exp_r.spin_after) begin
                    $error("spin_after: expected %0d, got %0d", exp_r.spin_after,
                           got.spin_after);
                    errors++;
                end
                if (got.bond_sum !== exp_r.bond_sum) begin
                    $error("bond_sum: expected %0d, got %0d", exp_r.bond_sum, got.bond_sum);
                    errors++;
                end
                if (got.magnetization !== exp_r.magnetization) begin
                    $error("magnetization: expected %0d, got %0d", exp_r.magnetization,
                           got.magnetization);
                    errors++;
                end
                if (got.attempted !== exp_r.attempted) begin
                    $error("attempted_count: expected %0d, got %0d", exp_r.attempted,
                           got.attempted);
                    errors++;
                end
                if (got.accepted !== exp_r.accepted) begin
                    $error("accepted_count: expected %0d, got %0d", exp_r.accepted,
                           got.accepted);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ising_ring_spin_flip_update_core verification failed");
                $finish;
            end
        end
    end

    initial begin
        reset_ring_model();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_thresholds();
        test_directed_classes();
        test_random_phases();
        test_output_backpressure();
        test_no_idle_stream();
        repeat (12) @(negedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("ising_ring_spin_flip_update_core verification clean");
        else
            $display("ising_ring_spin_flip_update_core verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/isr_pkg.sv
hdl/isr_ram.sv
hdl/ising_ring_spin_flip_update_core.sv
sim/testbench.sv
